@@ hdl/sha1bh_pkg.sv @@
// Shared types, constants and round helpers for the SHA-1 block hash.
package sha1bh_pkg;

	localparam int Rounds      = 80;
	localparam int BlockWords  = 16;
	localparam int DigestWords = 5;
	localparam int RndCntW     = $clog2(Rounds);
	localparam int WordCntW    = $clog2(BlockWords);
	localparam int ChainAddrW  = $clog2(DigestWords);

	localparam logic [RndCntW-1:0] LastRound  = RndCntW'(Rounds - 1);
	localparam logic [RndCntW-1:0] SweepEnd   = RndCntW'(DigestWords);
	localparam logic [WordCntW-1:0] LastWord  = WordCntW'(BlockWords - 1);

	typedef struct packed {
		logic [31:0] message_word;
		logic        final_block;
	} sha1bh_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last;
	} sha1bh_out_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_ADD   = 4'b1000
	} sha1bh_state_t;

	typedef struct packed {
		logic                  rd_en;
		logic [ChainAddrW-1:0] rd_addr;
		logic                  upd_en;
		logic                  flush;
	} sha1bh_chain_ctl_t;

	typedef struct packed {
		logic               shift;
		logic               round_en;
		logic [RndCntW-1:0] round_idx;
	} sha1bh_core_ctl_t;

	function automatic logic [31:0] sha1bh_iv(input logic [ChainAddrW-1:0] idx);
		logic [31:0] v;
		unique case (idx)
			3'd0:    v = 32'h6745_2301;
			3'd1:    v = 32'hEFCD_AB89;
			3'd2:    v = 32'h98BA_DCFE;
			3'd3:    v = 32'h1032_5476;
			default: v = 32'hC3D2_E1F0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] sha1bh_rotl(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

@@ hdl/sha1bh_chain.sv @@
// Chaining value memory with per-entry valid bits and the final chaining add.
module sha1bh_chain (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sha1bh_pkg::sha1bh_chain_ctl_t ctl,
	input  logic [31:0]                addend,
	output logic [31:0]                h_word,
	output logic [31:0]                sum
);
	import sha1bh_pkg::*;

	logic [31:0]           mem [DigestWords];
	logic [DigestWords-1:0] valid_q;
	logic [31:0]           rd_data_q;
	logic                  rd_hit_q;
	logic [ChainAddrW-1:0] rd_idx_q;

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_addr];
			rd_idx_q  <= ctl.rd_addr;
		end
		if (ctl.upd_en) begin
			mem[rd_idx_q] <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (ctl.rd_en) begin
				rd_hit_q <= valid_q[ctl.rd_addr];
			end
			if (ctl.upd_en) begin
				valid_q[rd_idx_q] <= !ctl.flush;
			end
		end
	end

	assign h_word = rd_hit_q ? rd_data_q : sha1bh_iv(rd_idx_q);
	assign sum    = h_word + addend;

endmodule

@@ hdl/sha1bh_sched.sv @@
// Message schedule window as a 16-tap shift line.
module sha1bh_sched (
	input  logic        clk,
	input  logic        load,
	input  logic [31:0] word,
	input  logic        advance,
	output logic [31:0] w
);
	import sha1bh_pkg::*;

	logic [31:0] win_q [BlockWords];
	logic [31:0] next_w;

	assign next_w = load ? word
		: sha1bh_rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);

	always_ff @(posedge clk) begin
		if (load || advance) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BlockWords-1] <= next_w;
		end
	end

	assign w = win_q[0];

endmodule

@@ hdl/sha1bh_core.sv @@
// Working variables and the SHA-1 round function.
module sha1bh_core (
	input  logic                         clk,
	input  sha1bh_pkg::sha1bh_core_ctl_t ctl,
	input  logic [31:0]                  h_word,
	input  logic [31:0]                  w,
	output logic [31:0]                  a_word
);
	import sha1bh_pkg::*;

	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] f, k, tmp;

	always_comb begin
		if (ctl.round_idx < RndCntW'(20)) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A82_7999;
		end else if (ctl.round_idx < RndCntW'(40)) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9_EBA1;
		end else if (ctl.round_idx < RndCntW'(60)) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1B_BCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62_C1D6;
		end
		tmp = sha1bh_rotl(a_q, 5) + f + e_q + k + w;
	end

	always_ff @(posedge clk) begin
		if (ctl.round_en) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= sha1bh_rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end else if (ctl.shift) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= e_q;
			e_q <= h_word;
		end
	end

	assign a_word = a_q;

endmodule

@@ hdl/sha1_block_hash.sv @@
// Top level of the SHA-1 block hash: sequencer and item ports.
//
// Input: an item (one message word plus the final_block flag) is taken at a
// rising edge where start is high and busy is low. Words of a block arrive
// big-endian, sixteen per 512-bit block; the first fifteen leave busy low.
// The sixteenth word starts the compression and holds busy high while the
// chaining words are read from memory into the working variables, through
// 80 rounds at one round per cycle, and through the chaining add, which
// reads, adds and writes back one chaining word per cycle.
// Output: if the sixteenth word carried final_block, the five digest words
// appear on consecutive cycles, h0 first, digest_valid high for one cycle
// each, last set on the fifth; they come during the chaining add, after the
// load and the rounds. The receiver cannot stall; each word must be
// taken in its cycle. After the digest the chaining value reverts to the
// standard initial values.
// Reset clears the word count, the sequencer and the chaining value valid
// bits, so the chaining value reads as the initial values.
module sha1_block_hash (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  sha1bh_pkg::sha1bh_in_t  message,
	output logic                    digest_valid,
	output sha1bh_pkg::sha1bh_out_t digest
);
	import sha1bh_pkg::*;

	sha1bh_state_t         state_q;
	logic [RndCntW-1:0]    cnt_q;
	logic [WordCntW-1:0]   word_cnt_q;
	logic                  final_q;
	logic                  accept;
	sha1bh_chain_ctl_t     chain_ctl;
	sha1bh_core_ctl_t      core_ctl;
	logic [31:0]           h_word;
	logic [31:0]           sum;
	logic [31:0]           w;
	logic [31:0]           a_word;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			word_cnt_q <= '0;
			final_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						word_cnt_q <= word_cnt_q + 1'b1;
						if (word_cnt_q == LastWord) begin
							final_q <= message.final_block;
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					if (cnt_q == SweepEnd) begin
						cnt_q   <= '0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ROUND: begin
					if (cnt_q == LastRound) begin
						cnt_q   <= '0;
						state_q <= ST_ADD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ADD: begin
					if (cnt_q == SweepEnd) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		chain_ctl.rd_en   = ((state_q == ST_LOAD) || (state_q == ST_ADD)) && (cnt_q < SweepEnd);
		chain_ctl.rd_addr = cnt_q[ChainAddrW-1:0];
		chain_ctl.upd_en  = (state_q == ST_ADD) && (cnt_q != '0);
		chain_ctl.flush   = final_q;
		core_ctl.shift     = ((state_q == ST_LOAD) || (state_q == ST_ADD)) && (cnt_q != '0);
		core_ctl.round_en  = (state_q == ST_ROUND);
		core_ctl.round_idx = cnt_q;
	end

	sha1bh_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (chain_ctl),
		.addend (a_word),
		.h_word (h_word),
		.sum    (sum)
	);

	sha1bh_sched u_sched (
		.clk     (clk),
		.load    (accept),
		.word    (message.message_word),
		.advance (core_ctl.round_en),
		.w       (w)
	);

	sha1bh_core u_core (
		.clk    (clk),
		.ctl    (core_ctl),
		.h_word (h_word),
		.w      (w),
		.a_word (a_word)
	);

	assign digest_valid       = chain_ctl.upd_en && final_q;
	assign digest.digest_word = sum;
	assign digest.last        = (cnt_q == SweepEnd);

endmodule

@@ test/sha1_block_hash_test.sv @@
// Self-checking testbench for the SHA-1 block hash: predicts every digest item and checks it.
module sha1_block_hash_test;
	import sha1bh_pkg::*;

	localparam int unsigned TimeoutCycles = 200000;
	localparam int unsigned SettleCycles  = 120;
	localparam int unsigned ReportLimit   = 10;

	typedef enum {FILL_ZERO, FILL_ONES, FILL_ABC, FILL_MIXED} fill_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	sha1bh_in_t  message;
	logic        digest_valid;
	sha1bh_out_t digest;

	logic [31:0]  hash_state [DigestWords];
	logic [31:0]  block_words [BlockWords];
	int unsigned  word_pos;
	sha1bh_out_t  digest_expected [$];

	int unsigned idle_pct;
	int unsigned mismatches;
	int unsigned digest_items;
	int unsigned items_sent;
	int unsigned messages_sent;
	int unsigned cycle_cnt;

	sha1_block_hash dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.message      (message),
		.digest_valid (digest_valid),
		.digest       (digest)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= TimeoutCycles) begin
			$display("Timeout after %0d cycles, %0d digest items pending",
				cycle_cnt, digest_expected.size());
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic void load_init_hash();
		hash_state[0] = 32'h6745_2301;
		hash_state[1] = 32'hEFCD_AB89;
		hash_state[2] = 32'h98BA_DCFE;
		hash_state[3] = 32'h1032_5476;
		hash_state[4] = 32'hC3D2_E1F0;
	endfunction

	function automatic void compress_block();
		logic [31:0] a, b, c, d, e, f, k, tmp;
		logic [31:0] sched [BlockWords];
		sched = block_words;
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int r = 0; r < Rounds; r++) begin
			if (r >= BlockWords) begin
				sched[r % 16] = rol(sched[(r - 3) % 16] ^ sched[(r - 8) % 16]
					^ sched[(r - 14) % 16] ^ sched[r % 16], 1);
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A82_7999;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9_EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1B_BCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62_C1D6;
			end
			tmp = rol(a, 5) + f + e + k + sched[r % 16];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = tmp;
		end
		hash_state[0] = hash_state[0] + a;
		hash_state[1] = hash_state[1] + b;
		hash_state[2] = hash_state[2] + c;
		hash_state[3] = hash_state[3] + d;
		hash_state[4] = hash_state[4] + e;
	endfunction

	function automatic void predict_digest(input sha1bh_in_t item);
		sha1bh_out_t res;
		block_words[word_pos] = item.message_word;
		word_pos = (word_pos + 1) % BlockWords;
		if (word_pos != 0)
			return;
		compress_block();
		if (!item.final_block)
			return;
		for (int i = 0; i < DigestWords; i++) begin
			res.digest_word = hash_state[i];
			res.last = (i == DigestWords - 1);
			digest_expected.push_back(res);
		end
		load_init_hash();
	endfunction

	function automatic logic [31:0] mixed_word();
		unique case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h1 << $urandom_range(31);
			3: return ~(32'h1 << $urandom_range(31));
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		sha1bh_out_t want;
		if (arst_n && digest_valid) begin
			digest_items++;
			if (digest_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportLimit)
					$display("Unexpected digest item %h last=%b", digest.digest_word, digest.last);
			end else begin
				want = digest_expected.pop_front();
				if (digest.digest_word !== want.digest_word || digest.last !== want.last) begin
					mismatches++;
					if (mismatches <= ReportLimit)
						$display("Digest mismatch: expected %h last=%b, got %h last=%b",
							want.digest_word, want.last, digest.digest_word, digest.last);
				end
			end
		end
	end

	task automatic send_word(input logic [31:0] word, input logic fin);
		sha1bh_in_t item;
		item.message_word = word;
		item.final_block = fin;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		message <= item;
		do @(posedge clk); while (busy);
		predict_digest(item);
		items_sent++;
	endtask

	task automatic send_block(input fill_t fill, input logic fin, input int unsigned flag_pct);
		logic [31:0] word;
		logic flag;
		for (int i = 0; i < BlockWords; i++) begin
			unique case (fill)
				FILL_ZERO: word = '0;
				FILL_ONES: word = '1;
				FILL_ABC:  word = (i == 0) ? 32'h6162_6380 : (i == BlockWords - 1) ? 32'h18 : '0;
				default:   word = mixed_word();
			endcase
			flag = (i == BlockWords - 1) ? fin : ($urandom_range(99) < flag_pct);
			send_word(word, flag);
		end
	endtask

	// hold off until every predicted digest item has come out
	task automatic wait_digests();
		start <= 1'b0;
		do @(posedge clk); while (digest_expected.size() != 0);
	endtask

	task automatic test_extreme_words();
		idle_pct = 0;
		send_block(FILL_ZERO, 1'b1, 0);
		wait_digests();
	endtask

	task automatic test_flag_mid_block();
		idle_pct = 0;
		send_block(FILL_ONES, 1'b0, 100);
		send_block(FILL_ABC, 1'b1, 0);
		wait_digests();
	endtask

	task automatic test_random_messages(input int unsigned sender_idle, input int unsigned count);
		int unsigned blocks;
		int unsigned noise;
		idle_pct = sender_idle;
		repeat (count) begin
			blocks = ($urandom_range(3) == 0) ? 2 : 1;
			if ($urandom_range(9) == 0)
				blocks = 3;
			noise = ($urandom_range(1) == 0) ? 0 : 30;
			for (int n = 1; n <= blocks; n++)
				send_block(FILL_MIXED, n == blocks, noise);
			messages_sent++;
			if ($urandom_range(3) == 0)
				wait_digests();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		message = '0;
		cycle_cnt = 0;
		mismatches = 0;
		digest_items = 0;
		items_sent = 0;
		messages_sent = 0;
		idle_pct = 0;
		word_pos = 0;
		load_init_hash();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_words();
		test_flag_mid_block();
		test_random_messages(37, 2);
		test_random_messages(77, 1);
		test_random_messages(0, 1);

		wait_digests();
		repeat (SettleCycles) @(posedge clk);
		$display("Sent %0d message words in %0d random and 2 directed messages,",
			items_sent, messages_sent);
		$display("checked %0d digest items with sender idling at 37, 77 and 0 percent",
			digest_items);
		if (mismatches == 0 && digest_expected.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d digest items missing", mismatches,
				digest_expected.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/sha1bh_pkg.sv
hdl/sha1bh_chain.sv
hdl/sha1bh_sched.sv
hdl/sha1bh_core.sv
hdl/sha1_block_hash.sv
test/sha1_block_hash_test.sv
